FILE: rtl/bfsa_pkg.sv
// Shared types, codes and sizes of the best-fit segment allocator.
package bfsa_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_W        = $clog2(MAX_SEGMENTS);
    localparam int ADDR_BITS    = 32;
    localparam int LEN_W        = 32;
    localparam int ALIGN_W      = 5;
    localparam int MAX_ALIGN    = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int STEP_W       = 32;

    typedef logic [SEG_W-1:0] t_idx;

    localparam t_idx LAST_IDX = t_idx'(MAX_SEGMENTS - 1);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MOVE  = 2'd2,
        OP_INIT  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NO_FIT  = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_FULL    = 3'd3,
        ST_REFUSED = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE   = 2'd0,
        CFG_POOL_SIZE   = 2'd1,
        CFG_ALIGN_SHIFT = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_opcode              opcode;
        logic [LEN_W-1:0]     request_size;
        logic [ADDR_BITS-1:0] old_address;
        logic [ADDR_BITS-1:0] new_address;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [ADDR_BITS-1:0] result_address;
        logic [LEN_W-1:0]     allocated_total;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [LEN_W-1:0]     len;
        logic                 free;
        t_idx                 next;
        t_idx                 prev;
    } t_seg;

    typedef struct packed {
        logic base;
        logic len;
        logic free;
        logic next;
        logic prev;
    } t_seg_we;

    typedef enum logic [STEP_W-1:0] {
        S_IDLE     = 32'h0000_0001,
        S_DECODE   = 32'h0000_0002,
        S_INIT     = 32'h0000_0004,
        S_A_START  = 32'h0000_0008,
        S_A_WALK   = 32'h0000_0010,
        S_A_DECIDE = 32'h0000_0020,
        S_A_GET    = 32'h0000_0040,
        S_A_SPLIT1 = 32'h0000_0080,
        S_A_SPLIT2 = 32'h0000_0100,
        S_A_FIN    = 32'h0000_0200,
        S_F_START  = 32'h0000_0400,
        S_F_SCAN   = 32'h0000_0800,
        S_R_HIT    = 32'h0000_1000,
        S_R_GP     = 32'h0000_2000,
        S_C_EV     = 32'h0000_4000,
        S_C_LINK   = 32'h0000_8000,
        S_C_END    = 32'h0001_0000,
        S_R_GN     = 32'h0002_0000,
        S_R_LINK   = 32'h0004_0000,
        S_M_HIT    = 32'h0008_0000,
        S_M_GP     = 32'h0010_0000,
        S_M_G1     = 32'h0020_0000,
        S_M_G2     = 32'h0040_0000,
        S_M_G3     = 32'h0080_0000,
        S_M_H1     = 32'h0100_0000,
        S_M_P1     = 32'h0200_0000,
        S_M_P2     = 32'h0400_0000,
        S_M_SET    = 32'h0800_0000,
        S_M_F1     = 32'h1000_0000,
        S_M_F2     = 32'h2000_0000,
        S_M_F3     = 32'h4000_0000,
        S_DONE     = 32'h8000_0000
    } t_step;

    typedef struct packed {
        t_opcode op;
        logic    a_fail;
        logic    walk_stop;
        logic    best_ok;
        logic    split;
        logic    spare_ok;
        logic    s_last;
        logic    hit;
        logic    scan_end;
        logic    back;
        logic    has_n;
        logic    cur_free;
        logic    cur_hn;
        logic    n_free;
        logic    hp;
        logic    same;
        logic    down;
        logic    down_ok;
        logic    up_ok;
        logic    pfree_up;
        logic    unl_hp;
        logic    out_free;
    } t_dp_flags;

endpackage

FILE: rtl/bfsa_ctrl.sv
// Sequencer that steps the allocator datapath through each operation.
module bfsa_ctrl import bfsa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_dp_flags i_flags,
    output t_step     o_step,
    output logic      o_in_ready
);

    t_step r_step;
    t_step n_step;

    always_comb begin
        n_step = r_step;
        unique case (r_step)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_step = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_flags.op)
                    OP_ALLOC: n_step = S_A_START;
                    OP_FREE:  n_step = S_F_START;
                    OP_MOVE:  n_step = S_F_START;
                    OP_INIT:  n_step = S_INIT;
                endcase
            end
            S_INIT:    n_step = S_DONE;
            S_A_START: n_step = i_flags.a_fail ? S_DONE : S_A_WALK;
            S_A_WALK: begin
                if (i_flags.walk_stop) begin
                    n_step = S_A_DECIDE;
                end
            end
            S_A_DECIDE: begin
                priority if (!i_flags.best_ok) begin
                    n_step = S_DONE;
                end else if (i_flags.split && !i_flags.spare_ok) begin
                    n_step = S_DONE;
                end else begin
                    n_step = S_A_GET;
                end
            end
            S_A_GET:    n_step = i_flags.split ? S_A_SPLIT1 : S_A_FIN;
            S_A_SPLIT1: n_step = i_flags.s_last ? S_A_FIN : S_A_SPLIT2;
            S_A_SPLIT2: n_step = S_A_FIN;
            S_A_FIN:    n_step = S_DONE;
            S_F_START:  n_step = S_F_SCAN;
            S_F_SCAN: begin
                priority if (i_flags.hit) begin
                    n_step = (i_flags.op == OP_FREE) ? S_R_HIT : S_M_HIT;
                end else if (i_flags.scan_end) begin
                    n_step = S_DONE;
                end
            end
            S_R_HIT: n_step = S_R_GP;
            S_R_GP: begin
                priority if (i_flags.back) begin
                    n_step = S_C_EV;
                end else if (i_flags.has_n) begin
                    n_step = S_R_GN;
                end else begin
                    n_step = S_DONE;
                end
            end
            S_C_EV: begin
                priority if (i_flags.cur_free && i_flags.cur_hn) begin
                    n_step = S_C_LINK;
                end else begin
                    n_step = S_C_END;
                end
            end
            S_C_LINK: n_step = S_C_EV;
            S_C_END:  n_step = S_DONE;
            S_R_GN:   n_step = (i_flags.n_free && i_flags.hp) ? S_R_LINK : S_DONE;
            S_R_LINK: n_step = S_DONE;
            S_M_HIT:  n_step = i_flags.same ? S_DONE : S_M_GP;
            S_M_GP: begin
                priority if (i_flags.down) begin
                    n_step = i_flags.down_ok ? S_M_G1 : S_DONE;
                end else if (!i_flags.up_ok) begin
                    n_step = S_DONE;
                end else if (i_flags.pfree_up) begin
                    n_step = S_M_H1;
                end else if (!i_flags.spare_ok) begin
                    n_step = S_DONE;
                end else if (i_flags.hp) begin
                    n_step = S_M_P1;
                end else begin
                    n_step = S_M_F1;
                end
            end
            S_M_G1:  n_step = S_M_G2;
            S_M_G2:  n_step = i_flags.unl_hp ? S_M_G3 : S_DONE;
            S_M_G3:  n_step = S_DONE;
            S_M_H1:  n_step = S_M_SET;
            S_M_P1:  n_step = S_M_P2;
            S_M_P2:  n_step = S_M_SET;
            S_M_SET: n_step = S_DONE;
            S_M_F1:  n_step = S_M_F2;
            S_M_F2:  n_step = i_flags.s_last ? S_DONE : S_M_F3;
            S_M_F3:  n_step = S_DONE;
            S_DONE: begin
                if (i_flags.out_free) begin
                    n_step = S_IDLE;
                end
            end
            default: n_step = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_step     = r_step;
    assign o_in_ready = (r_step == S_IDLE);

endmodule

FILE: rtl/bfsa_datapath.sv
// Segment table memories, working registers and result register of the allocator.
module bfsa_datapath import bfsa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_step                i_step,
    input  logic                 i_in_valid,
    input  t_in_item             i_in_data,
    input  logic                 i_out_ready,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output t_dp_flags            o_flags,
    output logic                 o_out_valid,
    output t_out_item            o_out_data
);

    logic [ADDR_BITS-1:0] r_mem_base [MAX_SEGMENTS];
    logic [LEN_W-1:0]     r_mem_len  [MAX_SEGMENTS];
    logic                 r_mem_free [MAX_SEGMENTS];
    t_idx                 r_mem_next [MAX_SEGMENTS];
    t_idx                 r_mem_prev [MAX_SEGMENTS];

    logic [ADDR_BITS-1:0]    r_cfg_base;
    logic [LEN_W-1:0]        r_cfg_size;
    logic [ALIGN_W-1:0]      r_cfg_shift;
    logic [MAX_SEGMENTS-1:0] r_used;
    t_idx                    r_first;
    logic [LEN_W-1:0]        r_alloc;
    logic                    r_out_valid;
    t_out_item               r_out;

    t_in_item             r_in;
    t_seg                 r_rd;
    t_seg                 r_srec;
    t_seg                 r_prec;
    t_idx                 r_s;
    t_idx                 r_n;
    t_idx                 r_cur;
    t_idx                 r_k;
    t_idx                 r_best;
    logic                 r_best_ok;
    logic [LEN_W-1:0]     r_best_len;
    logic [LEN_W:0]       r_need;
    logic                 r_split;
    logic [LEN_W-1:0]     r_plen;
    logic [LEN_W-1:0]     r_adj;
    logic                 r_down;
    logic                 r_setprev;
    t_idx                 r_spare;
    logic                 r_spare_ok;
    t_status              r_res_status;
    logic [ADDR_BITS-1:0] r_res_addr;

    t_idx                 rd_addr;
    t_idx                 wr_addr;
    t_seg_we              we;
    t_seg                 wd;
    logic [ALIGN_W-1:0]   sh;
    logic [LEN_W:0]       amask;
    logic [LEN_W:0]       need_c;
    logic [LEN_W:0]       init_sum;
    logic [LEN_W-1:0]     init_size;
    logic                 fit;
    logic                 nb_ok;
    t_idx                 nb_idx;
    logic [LEN_W-1:0]     nb_len;
    logic                 unl;
    logic                 hp_p;
    logic                 out_free;
    logic [SEG_W:0]       spare_c;
    t_dp_flags            flags;

    function automatic logic [SEG_W:0] first_zero(input logic [MAX_SEGMENTS-1:0] v);
        logic [SEG_W:0] res;
        res = (SEG_W + 1)'(MAX_SEGMENTS);
        for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                res = (SEG_W + 1)'(i);
            end
        end
        return res;
    endfunction

    assign sh        = (r_cfg_shift > ALIGN_W'(MAX_ALIGN)) ? ALIGN_W'(MAX_ALIGN) : r_cfg_shift;
    assign amask     = ((LEN_W + 1)'(1) << sh) - (LEN_W + 1)'(1);
    assign need_c    = ({1'b0, r_in.request_size} + amask) & ~amask;
    assign init_sum  = {1'b0, r_cfg_base} + {1'b0, r_cfg_size};
    assign init_size = (init_sum > {1'b0, {LEN_W{1'b1}}}) ? ~r_cfg_base : r_cfg_size;
    assign spare_c   = first_zero(r_used);

    assign fit    = r_rd.free && ({1'b0, r_rd.len} >= r_need)
                    && (!r_best_ok || (r_rd.len < r_best_len));
    assign nb_ok  = r_best_ok || fit;
    assign nb_idx = fit ? r_cur : r_best;
    assign nb_len = fit ? r_rd.len : r_best_len;

    assign unl      = (r_prec.len == r_adj);
    assign hp_p     = (r_prec.prev != r_srec.prev);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        flags           = '0;
        flags.op        = r_in.opcode;
        flags.a_fail    = (r_in.request_size == '0) || !r_used[r_first];
        flags.walk_stop = (nb_ok && ({1'b0, nb_len} == r_need)) || (r_rd.next == r_cur)
                          || (r_k == LAST_IDX);
        flags.best_ok   = r_best_ok;
        flags.split     = ({1'b0, r_best_len} > r_need);
        flags.spare_ok  = r_spare_ok;
        flags.s_last    = (r_srec.next == r_s);
        flags.hit       = r_used[r_k] && !r_rd.free && (r_rd.base == r_in.old_address);
        flags.scan_end  = (r_k == LAST_IDX);
        flags.back      = (r_srec.prev != r_s) && r_rd.free;
        flags.has_n     = (r_srec.next != r_s);
        flags.cur_free  = r_rd.free;
        flags.cur_hn    = (r_rd.next != r_cur);
        flags.n_free    = r_rd.free;
        flags.hp        = (r_srec.prev != r_s);
        flags.same      = (r_in.new_address == r_in.old_address);
        flags.down      = r_down;
        flags.pfree_up  = (r_srec.prev != r_s) && r_rd.free;
        flags.down_ok   = flags.pfree_up && (r_rd.len >= r_adj);
        flags.up_ok     = (r_adj < r_srec.len);
        flags.unl_hp    = unl && hp_p;
        flags.out_free  = out_free;
    end

    assign o_flags = flags;

    always_comb begin
        rd_addr = r_cur;
        wr_addr = r_s;
        we      = '0;
        wd      = r_srec;
        unique case (i_step)
            S_INIT: begin
                wr_addr = '0;
                we      = (init_size != '0) ? '1 : '0;
                wd      = '{base: r_cfg_base, len: init_size, free: 1'b1,
                            next: '0, prev: '0};
            end
            S_A_START:  rd_addr = r_first;
            S_A_WALK:   rd_addr = r_rd.next;
            S_A_DECIDE: rd_addr = r_best;
            S_A_SPLIT1: begin
                wr_addr = r_n;
                we      = '1;
                wd      = '{base: r_srec.base + r_need[LEN_W-1:0],
                            len: r_srec.len - r_need[LEN_W-1:0], free: 1'b1,
                            next: flags.s_last ? r_n : r_srec.next, prev: r_s};
            end
            S_A_SPLIT2: begin
                wr_addr = r_srec.next;
                we.prev = 1'b1;
                wd.prev = r_n;
            end
            S_A_FIN: begin
                we.len  = 1'b1;
                we.free = 1'b1;
                we.next = 1'b1;
                wd.len  = r_need[LEN_W-1:0];
                wd.free = 1'b0;
                wd.next = r_split ? r_n : r_srec.next;
            end
            S_F_START: rd_addr = '0;
            S_F_SCAN:  rd_addr = t_idx'(r_k + 1'b1);
            S_R_HIT: begin
                rd_addr = r_srec.prev;
                we.free = 1'b1;
                wd.free = 1'b1;
            end
            S_R_GP: rd_addr = flags.back ? r_s : r_srec.next;
            S_C_EV: begin
                wr_addr = r_srec.prev;
                we.next = r_rd.free;
                wd.next = flags.cur_hn ? r_rd.next : r_srec.prev;
            end
            S_C_LINK: begin
                wr_addr = r_cur;
                we.prev = 1'b1;
                wd.prev = r_srec.prev;
            end
            S_C_END: begin
                wr_addr = r_srec.prev;
                we.len  = 1'b1;
                wd.len  = r_plen;
            end
            S_R_GN: begin
                wr_addr = r_srec.next;
                we.base = r_rd.free;
                we.len  = r_rd.free;
                we.prev = r_rd.free;
                wd.base = r_srec.base;
                wd.len  = r_rd.len + r_srec.len;
                wd.prev = flags.hp ? r_srec.prev : r_srec.next;
            end
            S_R_LINK: begin
                wr_addr = r_srec.prev;
                we.next = 1'b1;
                wd.next = r_srec.next;
            end
            S_M_HIT: rd_addr = r_srec.prev;
            S_M_G1: begin
                wr_addr = r_srec.prev;
                we.len  = 1'b1;
                wd.len  = r_prec.len - r_adj;
            end
            S_M_G2: begin
                we.base = 1'b1;
                we.len  = 1'b1;
                we.prev = 1'b1;
                wd.base = r_in.new_address;
                wd.len  = r_srec.len + r_adj;
                wd.prev = unl ? (hp_p ? r_prec.prev : r_s) : r_srec.prev;
            end
            S_M_G3: begin
                wr_addr = r_prec.prev;
                we.next = 1'b1;
                wd.next = r_s;
            end
            S_M_H1: begin
                wr_addr = r_srec.prev;
                we.len  = 1'b1;
                wd.len  = r_prec.len + r_adj;
            end
            S_M_P1: begin
                wr_addr = r_n;
                we      = '1;
                wd      = '{base: r_prec.base + r_prec.len, len: r_adj, free: 1'b1,
                            next: r_s, prev: r_srec.prev};
            end
            S_M_P2: begin
                wr_addr = r_srec.prev;
                we.next = 1'b1;
                wd.next = r_n;
            end
            S_M_SET: begin
                we.base = 1'b1;
                we.len  = 1'b1;
                we.prev = 1'b1;
                wd.base = r_in.new_address;
                wd.len  = r_srec.len - r_adj;
                wd.prev = r_setprev ? r_n : r_srec.prev;
            end
            S_M_F1: begin
                wr_addr = r_n;
                we      = '1;
                wd      = '{base: r_srec.base + r_adj, len: r_srec.len - r_adj,
                            free: 1'b0, next: flags.s_last ? r_n : r_srec.next,
                            prev: r_s};
            end
            S_M_F2: begin
                we.next = 1'b1;
                we.len  = 1'b1;
                we.free = 1'b1;
                wd.next = r_n;
                wd.len  = r_adj;
                wd.free = 1'b1;
            end
            S_M_F3: begin
                wr_addr = r_srec.next;
                we.prev = 1'b1;
                wd.prev = r_n;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we.base) begin
            r_mem_base[wr_addr] <= wd.base;
        end
        if (we.len) begin
            r_mem_len[wr_addr] <= wd.len;
        end
        if (we.free) begin
            r_mem_free[wr_addr] <= wd.free;
        end
        if (we.next) begin
            r_mem_next[wr_addr] <= wd.next;
        end
        if (we.prev) begin
            r_mem_prev[wr_addr] <= wd.prev;
        end
        r_rd.base <= r_mem_base[rd_addr];
        r_rd.len  <= r_mem_len[rd_addr];
        r_rd.free <= r_mem_free[rd_addr];
        r_rd.next <= r_mem_next[rd_addr];
        r_rd.prev <= r_mem_prev[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base  <= '0;
            r_cfg_size  <= '0;
            r_cfg_shift <= '0;
            r_used      <= '0;
            r_first     <= '0;
            r_alloc     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_POOL_BASE) begin
                    r_cfg_base <= i_cfg_data;
                end
                if (i_cfg_index == CFG_POOL_SIZE) begin
                    r_cfg_size <= i_cfg_data;
                end
                if (i_cfg_index == CFG_ALIGN_SHIFT) begin
                    r_cfg_shift <= i_cfg_data[ALIGN_W-1:0];
                end
            end
            if (i_step == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_step)
                S_INIT: begin
                    r_used  <= {{(MAX_SEGMENTS - 1){1'b0}}, (init_size != '0)};
                    r_first <= '0;
                    r_alloc <= '0;
                end
                S_A_SPLIT1, S_M_P1, S_M_F1: r_used[r_n] <= 1'b1;
                S_A_FIN: r_alloc <= r_alloc + r_need[LEN_W-1:0];
                S_R_HIT: r_alloc <= r_alloc - r_srec.len;
                S_C_EV: begin
                    if (r_rd.free) begin
                        r_used[r_cur] <= 1'b0;
                    end
                end
                S_R_GN: begin
                    if (r_rd.free) begin
                        r_used[r_s] <= 1'b0;
                        if (!flags.hp) begin
                            r_first <= r_srec.next;
                        end
                    end
                end
                S_M_G2: begin
                    r_alloc <= r_alloc + r_adj;
                    if (unl) begin
                        r_used[r_srec.prev] <= 1'b0;
                        if (!hp_p) begin
                            r_first <= r_s;
                        end
                    end
                end
                S_M_SET, S_M_F2: r_alloc <= r_alloc - r_adj;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_spare    <= spare_c[SEG_W-1:0];
        r_spare_ok <= ~&r_used;
        if (i_step == S_DONE && out_free) begin
            r_out <= '{status: r_res_status, result_address: r_res_addr,
                       allocated_total: r_alloc};
        end
        unique case (i_step)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_in <= i_in_data;
                end
            end
            S_DECODE: begin
                r_res_status <= ST_OK;
                r_res_addr   <= '0;
                r_need       <= need_c;
            end
            S_INIT: r_res_addr <= r_cfg_base;
            S_A_START: begin
                r_cur     <= r_first;
                r_k       <= '0;
                r_best_ok <= 1'b0;
                if (flags.a_fail) begin
                    r_res_status <= ST_NO_FIT;
                end
            end
            S_A_WALK: begin
                r_best_ok  <= nb_ok;
                r_best     <= nb_idx;
                r_best_len <= nb_len;
                r_cur      <= r_rd.next;
                r_k        <= t_idx'(r_k + 1'b1);
            end
            S_A_DECIDE: begin
                r_s     <= r_best;
                r_split <= flags.split;
                r_n     <= r_spare;
                priority if (!r_best_ok) begin
                    r_res_status <= ST_NO_FIT;
                end else if (flags.split && !r_spare_ok) begin
                    r_res_status <= ST_FULL;
                end
            end
            S_A_GET: r_srec <= r_rd;
            S_A_FIN: r_res_addr <= r_srec.base;
            S_F_START: r_k <= '0;
            S_F_SCAN: begin
                r_k <= t_idx'(r_k + 1'b1);
                priority if (flags.hit) begin
                    r_s    <= r_k;
                    r_srec <= r_rd;
                end else if (flags.scan_end) begin
                    r_res_status <= ST_UNKNOWN;
                end
            end
            S_R_GP: begin
                r_plen <= r_rd.len;
                r_cur  <= r_s;
            end
            S_C_EV: begin
                if (r_rd.free) begin
                    r_plen <= r_plen + r_rd.len;
                    r_cur  <= r_rd.next;
                end
            end
            S_M_HIT: begin
                r_down <= (r_in.new_address < r_in.old_address);
                r_adj  <= (r_in.new_address < r_in.old_address)
                          ? (r_in.old_address - r_in.new_address)
                          : (r_in.new_address - r_in.old_address);
                if (flags.same) begin
                    r_res_addr <= r_in.new_address;
                end
            end
            S_M_GP: begin
                r_prec    <= r_rd;
                r_n       <= r_spare;
                r_setprev <= !flags.pfree_up;
                priority if (r_down) begin
                    if (!flags.down_ok) begin
                        r_res_status <= ST_REFUSED;
                    end
                end else if (!flags.up_ok) begin
                    r_res_status <= ST_REFUSED;
                end else if (!flags.pfree_up && !r_spare_ok) begin
                    r_res_status <= ST_FULL;
                end
            end
            S_M_G2, S_M_SET: r_res_addr <= r_in.new_address;
            S_M_F2: r_res_addr <= r_srec.base + r_adj;
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_walk_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step == S_A_WALK) |-> r_used[r_cur])
        else $error("Best-fit walk reached a slot that is not in use.");

    a_split_spare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step == S_A_SPLIT1 || i_step == S_M_P1 || i_step == S_M_F1) |-> !r_used[r_n])
        else $error("Split wrote into a slot that is already in use.");

    a_merge_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step == S_C_EV) |-> (r_cur != r_srec.prev))
        else $error("Backward merge tried to absorb its own target.");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step == S_DONE && out_free) |=> r_out_valid)
        else $error("Finished operation did not load the result register.");

endmodule

FILE: rtl/best_fit_segment_allocator.sv
// Top level of the best-fit segment allocator with coalescing.
// Each request beat is handled one at a time and gives one result beat. Allocate
// walks the address-ordered segment list one segment per cycle through the table
// memory's read port. Free and move first scan the table slots one per cycle for
// the base address, and free can then absorb following free segments. The next
// request is accepted as soon as the result is in the output register, even if it
// has not been taken yet. Configuration writes are always accepted; pool_base and
// pool_size take effect at the next initialize.
module best_fit_segment_allocator import bfsa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_step     step;
    t_dp_flags flags;

    bfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_flags    (flags),
        .o_step     (step),
        .o_in_ready (o_in_ready)
    );

    bfsa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_flags     (flags),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_cfg_ready = 1'b1;

endmodule
